>>> rtl/calibrated_gyro_attitude_integrator_unit_defines.svh
// assertion macros for the gyro attitude integrator
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef CALIBRATED_GYRO_ATTITUDE_INTEGRATOR_UNIT_DEFINES_SVH
`define CALIBRATED_GYRO_ATTITUDE_INTEGRATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check on clk_i, off while rst_ni is low
`define CGAI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check on an explicit clock and active-low reset
`define CGAI_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define CGAI_ASSERT(lbl, prop, msg)
`define CGAI_ASSERT_CR(lbl, clk, rstn, prop, msg)
`endif

`endif

>>> rtl/cgai_pkg.sv
// types, constants and helper functions for the gyro attitude integrator
// no dependencies
`default_nettype none

package cgai_pkg;

  // field and datapath widths
  localparam int RATE_W     = 24;
  localparam int CAL_W      = 18;
  localparam int CAL_ROW_W  = 3 * CAL_W;
  localparam int SCALE_W    = 32;
  localparam int D_W        = RATE_W + 1;
  localparam int W_RAW_W    = 45;
  localparam int ENT_W      = 32;
  localparam int B_W        = ENT_W + 1;
  localparam int MA_W       = 46;
  localparam int MB_W       = 18;
  localparam int P_W        = MA_W + MB_W;
  localparam int ACC_W      = 80;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CAL_ROW_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIASX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIASY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIASZ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd6;

  // register reset values
  localparam logic [CAL_ROW_W-1:0] CAL0_RST = 54'h0_0000_0001_0000;
  localparam logic [CAL_ROW_W-1:0] CAL1_RST = 54'h0_0004_0000_0000;
  localparam logic [CAL_ROW_W-1:0] CAL2_RST = 54'h10_0000_0000_0000;
  localparam logic [SCALE_W-1:0]   STEP_RST = 32'd749557;

  // fixed point constants
  localparam logic signed [ENT_W-1:0] ONE_Q28 = 32'sh1000_0000;
  localparam logic signed [ACC_W-1:0] RND30   = ACC_W'(64'sd536870912);
  localparam logic signed [ACC_W-1:0] RND28   = ACC_W'(64'sd134217728);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  typedef struct packed {
    logic                     first;
    logic                     last;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] m00;
    logic signed [ENT_W-1:0] m01;
    logic signed [ENT_W-1:0] m02;
    logic signed [ENT_W-1:0] m10;
    logic signed [ENT_W-1:0] m11;
    logic signed [ENT_W-1:0] m12;
    logic signed [ENT_W-1:0] m20;
    logic signed [ENT_W-1:0] m21;
    logic signed [ENT_W-1:0] m22;
    logic                    overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  // controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clear;
    logic shift16;
    logic sel30;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] value;
    logic                    sat;
  } res_t;

  // round half up at bit 30 or 28, then clamp to the signed 32-bit range
  function automatic res_t round_sat(input logic signed [ACC_W-1:0] acc, input logic sel30);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] s;
    res_t r;
    t = acc + (sel30 ? RND30 : RND28);
    s = sel30 ? (t >>> 30) : (t >>> 28);
    if (s > SAT_MAX) begin
      r.value = 32'sh7fff_ffff;
      r.sat   = 1'b1;
    end else if (s < SAT_MIN) begin
      r.value = 32'sh8000_0000;
      r.sat   = 1'b1;
    end else begin
      r.value = s[ENT_W-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  // entry (k, j) of I + hat(w)
  function automatic logic signed [B_W-1:0] step_entry(
    input logic signed [ENT_W-1:0] w0,
    input logic signed [ENT_W-1:0] w1,
    input logic signed [ENT_W-1:0] w2,
    input logic [1:0]              k,
    input logic [1:0]              j
  );
    logic signed [B_W-1:0] e;
    unique case ({k, j})
      4'b0000, 4'b0101, 4'b1010: e = B_W'(ONE_Q28);
      4'b0001: e = -B_W'(w2);
      4'b0010: e = B_W'(w1);
      4'b0100: e = B_W'(w2);
      4'b0110: e = -B_W'(w0);
      4'b1000: e = -B_W'(w1);
      4'b1001: e = B_W'(w0);
      default: e = '0;
    endcase
    return e;
  endfunction

  // row-major place of a 3x3 entry
  function automatic logic [3:0] ent_idx(input logic [1:0] r, input logic [1:0] c);
    return 4'(r) * 4'd3 + 4'(c);
  endfunction

endpackage

`default_nettype wire

>>> rtl/cgai_if.sv
// valid/ready channels of the gyro attitude integrator
// depends on cgai_pkg for the payload types
`default_nettype none

interface cgai_in_if import cgai_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cgai_out_if import cgai_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cgai_cfg_if import cgai_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/calibrated_gyro_attitude_integrator_unit.sv
// top level of the gyro attitude integrator: registers, sequencer, attitude state
// depends on cgai_pkg, cgai_if, cgai_mac and the assertion macro header
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   first, last, rate_x, rate_y, rate_z
//   out_o    out  valid/ready   m00..m22, overflow
//   cfg_i    in   valid/ready   idx, data (always ready)
//
// one item runs 69 multiply-accumulate steps (9 calibration, 6 angle scaling, 54 matrix
// product halves) on the one 46x18 multiplier, each a multiply then an accumulate phase
// reset sets the attitude to identity, clears the overflow flag and loads register defaults
// a finished result sits in the output register while the next item is taken; the final
// step of an item holds only if that register is still full and not being drained
`default_nettype none
`include "calibrated_gyro_attitude_integrator_unit_defines.svh"

module calibrated_gyro_attitude_integrator_unit import cgai_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  cgai_in_if.sink    in_i,
  cgai_out_if.source out_o,
  cgai_cfg_if.sink   cfg_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [1:0] STG_CAL = 2'd0;
  localparam logic [1:0] STG_ANG = 2'd1;
  localparam logic [1:0] STG_MAT = 2'd2;

  // configuration
  logic [CAL_ROW_W-1:0]     cal_q [3];
  logic signed [RATE_W-1:0] bias_q [3];
  logic [SCALE_W-1:0]       step_q;

  // sequencer
  logic       state_q;
  logic [1:0] stg_q, i_q, j_q, k_q;
  logic       h_q, ph_q;
  logic       last_q;

  // working values
  logic signed [D_W-1:0]     d_q [3];
  logic signed [W_RAW_W-1:0] w_raw_q [3];
  logic signed [ENT_W-1:0]   ang_q [3];
  logic signed [ENT_W-1:0]   att_q [9];
  logic signed [ENT_W-1:0]   nm_q [9];
  logic                      sat_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic                     in_acc, out_acc;
  logic                     last_op, stall, step_go;
  mac_ctl_t                 ctl;
  logic signed [MA_W-1:0]   mac_a;
  logic signed [MB_W-1:0]   mac_b;
  logic signed [B_W-1:0]    bent;
  logic signed [W_RAW_W-1:0] sum;
  res_t                     res;
  logic [CAL_W-1:0]         cal_pick;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q[0]  <= CAL0_RST;
      cal_q[1]  <= CAL1_RST;
      cal_q[2]  <= CAL2_RST;
      bias_q[0] <= '0;
      bias_q[1] <= '0;
      bias_q[2] <= '0;
      step_q    <= STEP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.idx)
        REG_CAL0:  cal_q[0]  <= cfg_i.data.data;
        REG_CAL1:  cal_q[1]  <= cfg_i.data.data;
        REG_CAL2:  cal_q[2]  <= cfg_i.data.data;
        REG_BIASX: bias_q[0] <= cfg_i.data.data[RATE_W-1:0];
        REG_BIASY: bias_q[1] <= cfg_i.data.data[RATE_W-1:0];
        REG_BIASZ: bias_q[2] <= cfg_i.data.data[RATE_W-1:0];
        REG_STEP:  step_q    <= cfg_i.data.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // operand selection for the shared unit
  always_comb begin
    unique case (j_q)
      2'd0:    cal_pick = cal_q[i_q][CAL_W-1:0];
      2'd1:    cal_pick = cal_q[i_q][2*CAL_W-1:CAL_W];
      default: cal_pick = cal_q[i_q][3*CAL_W-1:2*CAL_W];
    endcase
    bent = step_entry(ang_q[0], ang_q[1], ang_q[2], k_q, j_q);
    ctl.mul_en  = (state_q == ST_RUN) && !ph_q;
    ctl.acc_en  = step_go;
    ctl.shift16 = 1'b0;
    ctl.sel30   = 1'b0;
    ctl.clear   = 1'b0;
    unique case (stg_q)
      STG_CAL: begin
        mac_a     = MA_W'(d_q[j_q]);
        mac_b     = cal_pick;
        ctl.clear = (j_q == 2'd0);
      end
      STG_ANG: begin
        mac_a       = MA_W'(w_raw_q[i_q]);
        mac_b       = h_q ? {2'b00, step_q[31:16]} : {2'b00, step_q[15:0]};
        ctl.clear   = !h_q;
        ctl.shift16 = h_q;
        ctl.sel30   = 1'b1;
      end
      default: begin
        mac_a       = MA_W'(att_q[ent_idx(i_q, k_q)]);
        mac_b       = h_q ? MB_W'($signed(bent[B_W-1:16])) : {2'b00, bent[15:0]};
        ctl.clear   = (k_q == 2'd0) && !h_q;
        ctl.shift16 = h_q;
      end
    endcase
  end

  cgai_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .sum_o (sum),
    .res_o (res)
  );

  // final step of an item and its hold for a last-marked item when the output register is busy
  assign last_op = (stg_q == STG_MAT) && (i_q == 2'd2) && (j_q == 2'd2) && (k_q == 2'd2) && h_q;
  assign stall   = last_op && last_q && out_valid_q && !out_o.ready;
  assign step_go = (state_q == ST_RUN) && ph_q && !stall;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stg_q   <= STG_CAL;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      h_q     <= 1'b0;
      ph_q    <= 1'b0;
      last_q  <= 1'b0;
    end else if (in_acc) begin
      state_q <= ST_RUN;
      stg_q   <= STG_CAL;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      h_q     <= 1'b0;
      ph_q    <= 1'b0;
      last_q  <= in_i.data.last;
    end else if (state_q == ST_RUN && !ph_q) begin
      ph_q <= 1'b1;
    end else if (step_go) begin
      ph_q <= 1'b0;
      unique case (stg_q)
        STG_CAL: begin
          if (j_q == 2'd2) begin
            j_q <= '0;
            if (i_q == 2'd2) begin
              stg_q <= STG_ANG;
              i_q   <= '0;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        STG_ANG: begin
          h_q <= !h_q;
          if (h_q) begin
            if (i_q == 2'd2) begin
              stg_q <= STG_MAT;
              i_q   <= '0;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
        end
        default: begin
          h_q <= !h_q;
          if (h_q) begin
            if (k_q == 2'd2) begin
              k_q <= '0;
              if (j_q == 2'd2) begin
                j_q <= '0;
                if (i_q == 2'd2) begin
                  i_q     <= '0;
                  stg_q   <= STG_CAL;
                  state_q <= ST_IDLE;
                end else begin
                  i_q <= i_q + 2'd1;
                end
              end else begin
                j_q <= j_q + 2'd1;
              end
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
      endcase
    end
  end

  // bias removal on accept, intermediate results as each sum finishes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      d_q[0] <= D_W'(in_i.data.rate_x) - D_W'(bias_q[0]);
      d_q[1] <= D_W'(in_i.data.rate_y) - D_W'(bias_q[1]);
      d_q[2] <= D_W'(in_i.data.rate_z) - D_W'(bias_q[2]);
    end
    if (step_go) begin
      if (stg_q == STG_CAL && j_q == 2'd2) begin
        w_raw_q[i_q] <= sum;
      end
      if (stg_q == STG_ANG && h_q) begin
        ang_q[i_q] <= res.value;
      end
      if (stg_q == STG_MAT && k_q == 2'd2 && h_q) begin
        nm_q[ent_idx(i_q, j_q)] <= res.value;
      end
    end
  end

  // attitude state and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 9; n++) begin
        att_q[n] <= (n % 4 == 0) ? ONE_Q28 : '0;
      end
      sat_q <= 1'b0;
    end else if (in_acc && in_i.data.first) begin
      for (int n = 0; n < 9; n++) begin
        att_q[n] <= (n % 4 == 0) ? ONE_Q28 : '0;
      end
      sat_q <= 1'b0;
    end else if (step_go) begin
      if (stg_q != STG_CAL && h_q && (stg_q == STG_ANG || k_q == 2'd2)) begin
        sat_q <= sat_q | res.sat;
      end
      if (last_op) begin
        for (int n = 0; n < 8; n++) begin
          att_q[n] <= nm_q[n];
        end
        att_q[8] <= res.value;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go && last_op && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && last_op && last_q) begin
      out_q.m00      <= nm_q[0];
      out_q.m01      <= nm_q[1];
      out_q.m02      <= nm_q[2];
      out_q.m10      <= nm_q[3];
      out_q.m11      <= nm_q[4];
      out_q.m12      <= nm_q[5];
      out_q.m20      <= nm_q[6];
      out_q.m21      <= nm_q[7];
      out_q.m22      <= res.value;
      out_q.overflow <= sat_q | res.sat;
    end
  end

  // checks
  `CGAI_ASSERT(a_busy_after_accept, in_acc |=> !in_i.ready, "input ready right after accept")
  `CGAI_ASSERT(a_phase_advance, (state_q == ST_RUN && !ph_q) |=> ph_q, "multiply phase not followed by accumulate")
  `CGAI_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(step_go && last_op && last_q), "result without a finished last item")
  `CGAI_ASSERT_CR(a_first_clears, clk_i, rst_ni, (in_acc && in_i.data.first) |=> !sat_q, "first mark did not clear overflow")

endmodule

`default_nettype wire

>>> rtl/cgai_mac.sv
// shared multiply-accumulate unit with rounding and saturation
// depends on cgai_pkg
`default_nettype none

module cgai_mac import cgai_pkg::*; (
  input  wire logic                      clk_i,
  input  wire mac_ctl_t                  ctl_i,
  input  wire logic signed [MA_W-1:0]    a_i,
  input  wire logic signed [MB_W-1:0]    b_i,
  output logic signed [W_RAW_W-1:0]      sum_o,
  output res_t                           res_o
);

  logic signed [P_W-1:0]   prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] prod_ext;

  // registered product
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  // accumulate, upper half of a split operand weighs 2^16
  always_comb begin
    prod_ext = ACC_W'(prod_q);
    acc_d    = (ctl_i.clear ? '0 : acc_q) + (ctl_i.shift16 ? (prod_ext <<< 16) : prod_ext);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign sum_o = acc_d[W_RAW_W-1:0];
  assign res_o = round_sat(acc_d, ctl_i.sel30);

endmodule

`default_nettype wire

>>> verif/tb_attitude_checker.sv
`timescale 1ns / 1ps
// checker for the gyro attitude integrator: watches the input, output and register channels,
// predicts each emitted attitude matrix and compares it; depends on cgai_pkg and cgai_if
`default_nettype none

module tb_attitude_checker import cgai_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  cgai_in_if.sink    in_mon,
  cgai_out_if.sink   out_mon,
  cgai_cfg_if.sink   cfg_mon,
  output int         fail_count,
  output int         pending_count
);

  // predicted register copies and state
  logic [CAL_ROW_W-1:0] cal_row [3];
  logic signed [RATE_W-1:0] bias [3];
  logic [SCALE_W-1:0] step_scale;
  longint att [9];
  bit sat_seen;
  out_item_t matrix_q [$];

  // clamp to signed 32 bits, noting saturation
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint cal_coef(input int r, input int c);
    logic signed [CAL_W-1:0] e;
    e = cal_row[r][CAL_W*c +: CAL_W];
    return longint'(e);
  endfunction

  // angle in Q4.28 from a calibrated rate with LSB 2^-26 deg/s
  function automatic longint rate_to_angle(input longint w);
    longint hi, lo, p, q, x;
    hi = longint'(step_scale[31:16]);
    lo = longint'(step_scale[15:0]);
    p = w * hi;
    q = w * lo + (64'sd1 << 29);
    x = p + (q >>> 16);
    return clamp32(x >>> 14);
  endfunction

  task automatic set_identity();
    for (int i = 0; i < 9; i++) att[i] = (i % 4 == 0) ? (64'sd1 << 28) : 0;
  endtask

  // one gyro sample through the integrator
  task automatic integrate_sample(input in_item_t s);
    longint d [3];
    longint w [3];
    longint b [9];
    longint na [9];
    longint acc, hsum, lsum, p;
    out_item_t m;
    if (s.first) begin
      set_identity();
      sat_seen = 1'b0;
    end
    d[0] = longint'(s.rate_x) - longint'(bias[0]);
    d[1] = longint'(s.rate_y) - longint'(bias[1]);
    d[2] = longint'(s.rate_z) - longint'(bias[2]);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += cal_coef(i, j) * d[j];
      w[i] = rate_to_angle(acc);
    end
    b[0] = 64'sd1 << 28; b[1] = -w[2]; b[2] = w[1];
    b[3] = w[2]; b[4] = 64'sd1 << 28; b[5] = -w[0];
    b[6] = -w[1]; b[7] = w[0]; b[8] = 64'sd1 << 28;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        hsum = 0;
        lsum = 0;
        for (int k = 0; k < 3; k++) begin
          p = att[i*3+k] * b[k*3+j];
          hsum += p >>> 2;
          lsum += p & 64'sd3;
        end
        hsum += (lsum + (64'sd1 << 27)) >>> 2;
        na[i*3+j] = clamp32(hsum >>> 26);
      end
    end
    for (int i = 0; i < 9; i++) att[i] = na[i];
    if (s.last) begin
      m.m00 = att[0][31:0]; m.m01 = att[1][31:0]; m.m02 = att[2][31:0];
      m.m10 = att[3][31:0]; m.m11 = att[4][31:0]; m.m12 = att[5][31:0];
      m.m20 = att[6][31:0]; m.m21 = att[7][31:0]; m.m22 = att[8][31:0];
      m.overflow = sat_seen;
      matrix_q.insert(matrix_q.size(), m);
    end
  endtask

  // monitor all channels
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_m;
    if (!rst_ni) begin
      cal_row[0] = CAL0_RST;
      cal_row[1] = CAL1_RST;
      cal_row[2] = CAL2_RST;
      for (int i = 0; i < 3; i++) bias[i] = '0;
      step_scale = STEP_RST;
      set_identity();
      sat_seen = 1'b0;
      matrix_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.data.idx)
          REG_CAL0:  cal_row[0] = cfg_mon.data.data;
          REG_CAL1:  cal_row[1] = cfg_mon.data.data;
          REG_CAL2:  cal_row[2] = cfg_mon.data.data;
          REG_BIASX: bias[0] = cfg_mon.data.data[RATE_W-1:0];
          REG_BIASY: bias[1] = cfg_mon.data.data[RATE_W-1:0];
          REG_BIASZ: bias[2] = cfg_mon.data.data[RATE_W-1:0];
          REG_STEP:  step_scale = cfg_mon.data.data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (matrix_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected matrix item: %p", out_mon.data);
        end else begin
          exp_m = matrix_q.pop_front();
          if (exp_m !== out_mon.data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("matrix mismatch: expected %p actual %p", exp_m, out_mon.data);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) integrate_sample(in_mon.data);
    end
    pending_count = matrix_q.size();
  end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// stimulus and verdict for the gyro attitude integrator: directed then random sample runs
// depends on cgai_pkg, cgai_if, the integrator rtl and tb_attitude_checker
`default_nettype none

module tb_top import cgai_pkg::*;;

  localparam int IDLE_LIMIT = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;

  cgai_in_if  in_ch ();
  cgai_out_if out_ch ();
  cgai_cfg_if cfg_ch ();

  calibrated_gyro_attitude_integrator_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  tb_attitude_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch.sink),
    .out_mon      (out_ch.sink),
    .cfg_mon      (cfg_ch.sink),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side stalls
  bit ready_busy = 1'b0;
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = gap_len();
      if (ready_busy) n = 0;
      repeat (n) @(posedge clk_i);
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      n = $urandom_range(1, 6);
      repeat (n - 1) @(posedge clk_i);
      if (!ready_busy && $urandom_range(0, 1)) out_ch.ready <= 1'b0;
    end
  end

  task automatic send_sample(input bit f, input bit l, input logic [RATE_W-1:0] x,
                             input logic [RATE_W-1:0] y, input logic [RATE_W-1:0] z,
                             input bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{first: f, last: l, rate_x: x, rate_y: y, rate_z: z};
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  // wait until all matrices have come and the last sample has drained
  task automatic wait_drained();
    drop_valid();
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{idx: idx, data: v};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CAL_ROW_W-1:0] pack_row(input int c0, input int c1, input int c2);
    logic [CAL_W-1:0] e0, e1, e2;
    e0 = c0[CAL_W-1:0];
    e1 = c1[CAL_W-1:0];
    e2 = c2[CAL_W-1:0];
    return {e2, e1, e0};
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate(input int mode);
    case (mode)
      0: return RATE_W'($urandom);
      1: return RATE_W'($urandom_range(0, 4095) - 2048);
      default: return RATE_W'($urandom_range(0, 400000) - 200000);
    endcase
  endfunction

  // random intervals of well-formed first..last runs plus some loose samples
  task automatic random_phase(input int count, input int mode);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_rate(0),
                    rand_rate(0), rand_rate(0), 1);
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_sample(i == 0, i == len - 1, rand_rate(mode), rand_rate(mode), rand_rate(mode), 1);
        end
        sent += len;
      end
    end
  endtask

  task automatic random_config();
    for (int r = 0; r < 3; r++)
      write_reg(CFG_IDX_W'(REG_CAL0 + r), CFG_DATA_W'({$urandom, $urandom}));
    write_reg(REG_BIASX, CFG_DATA_W'($urandom));
    write_reg(REG_BIASY, CFG_DATA_W'($urandom));
    write_reg(REG_BIASZ, CFG_DATA_W'($urandom));
    write_reg(REG_STEP, CFG_DATA_W'($urandom));
  endtask

  localparam logic [RATE_W-1:0] RMAX = 24'h7f_ffff;
  localparam logic [RATE_W-1:0] RMIN = 24'h80_0000;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default registers, extremes and the marking cases
    send_sample(1, 1, 0, 0, 0, 0);
    send_sample(1, 1, RMAX, RMIN, RMAX, 0);
    send_sample(1, 0, RMIN, RMAX, RMIN, 0);
    send_sample(0, 0, 24'h1000, 24'hff_f000, 24'h400, 0);
    send_sample(0, 1, 24'h00_0001, 24'hff_ffff, 0, 0);
    send_sample(0, 1, RMAX, RMAX, RMAX, 1);
    send_sample(0, 0, 24'h55_5555, 24'haa_aaaa, 24'h33_3333, 1);
    // no first mark, interval keeps going
    send_sample(0, 1, 24'h12_3456, 24'hed_cba9, 24'h0f_0f0f, 1);
    wait_drained();

    // extreme registers drive angle and entry saturation
    write_reg(REG_CAL0, pack_row(131071, -131072, 131071));
    write_reg(REG_CAL1, pack_row(-131072, 131071, -131072));
    write_reg(REG_CAL2, pack_row(131071, 131071, -131072));
    write_reg(REG_BIASX, CFG_DATA_W'(RMIN));
    write_reg(REG_BIASY, CFG_DATA_W'(RMAX));
    write_reg(REG_BIASZ, CFG_DATA_W'(RMIN));
    write_reg(REG_STEP, CFG_DATA_W'(32'hffff_ffff));
    cfg_ch.data <= '{idx: 3'd7, data: '1};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    send_sample(1, 1, RMAX, RMIN, RMAX, 0);
    send_sample(0, 0, RMIN, RMIN, RMIN, 0);
    send_sample(0, 1, RMAX, RMAX, 0, 0);
    send_sample(1, 1, 0, 0, 0, 0);
    wait_drained();

    // zero registers
    for (int r = 0; r < 7; r++) write_reg(CFG_IDX_W'(REG_CAL0 + r), '0);
    send_sample(1, 1, RMAX, RMIN, 24'h1, 0);
    send_sample(0, 1, RMIN, RMAX, 24'h2, 0);
    wait_drained();

    // identity calibration, default scale, random runs
    write_reg(REG_CAL0, CAL0_RST);
    write_reg(REG_CAL1, CAL1_RST);
    write_reg(REG_CAL2, CAL2_RST);
    write_reg(REG_STEP, CFG_DATA_W'(STEP_RST));
    write_reg(REG_BIASX, CFG_DATA_W'(24'h000123));
    write_reg(REG_BIASY, CFG_DATA_W'(24'hfff000));
    write_reg(REG_BIASZ, CFG_DATA_W'(24'h000800));
    random_phase(300, 2);
    wait_drained();

    // random registers, small and full-range rates
    random_config();
    random_phase(250, 1);
    wait_drained();
    random_config();
    random_phase(250, 0);
    wait_drained();
    write_reg(REG_STEP, CFG_DATA_W'($urandom_range(0, 2000000)));
    random_phase(200, 2);
    wait_drained();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
